>>> rtl/fla_pkg.sv
// Package for the free-list block allocator.
// Holds status codes, defaults and the controller/datapath command structs.
// No dependencies.
`default_nettype none

package fla_pkg;

	// Default pool size and block count after reset
	localparam int POOL_DEPTH_DEF = 256;
	localparam int RESET_COUNT    = 256;

	// Opcodes of a request
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_GRANTED = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_FREED   = 2'd2;
	localparam status_t ST_RANGE   = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic    load_count; // take new block count, restart the link sweep
		logic    sweep_en;   // write one link of the initial chain
		logic    read_head;  // read the link of the current head
		logic    take_link;  // head <= link read in the previous cycle
		logic    push;       // link freed block to head, make it the head
		logic    emit;       // present a result next cycle
		status_t status;     // status of that result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic head_null;  // list is empty
		logic free_ok;    // free index is below the block count
		logic sweep_done; // every in-use link has been written
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/fla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fla_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/fla_ctrl.sv
// Controller of the free-list block allocator: sweep, idle and pop states.
// Depends on fla_pkg for the command and status structs and codes.
`default_nettype none

module fla_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          opcode,
	input  wire logic          cfg_we,
	input  wire fla_pkg::sts_t sts,
	output fla_pkg::cmd_t      cmd,
	output logic               busy
);

	import fla_pkg::*;

	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (cfg_we) begin
			cmd.load_count = 1'b1;
			state_d        = S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (sts.sweep_done) begin
						state_d = S_IDLE;
					end else begin
						cmd.sweep_en = 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd.emit = 1'b1;
						if (opcode == OP_ALLOC) begin
							if (sts.head_null) begin
								cmd.status = ST_EMPTY;
							end else begin
								cmd.status    = ST_GRANTED;
								cmd.read_head = 1'b1;
								state_d       = S_POP;
							end
						end else if (sts.free_ok) begin
							cmd.status = ST_FREED;
							cmd.push   = 1'b1;
						end else begin
							cmd.status = ST_RANGE;
						end
					end
				end
				S_POP: begin
					cmd.take_link = 1'b1;
					state_d       = S_IDLE;
				end
				default: begin
					state_d = S_INIT;
				end
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/fla_dp.sv
// Datapath of the free-list block allocator: head, count, sweep counter,
// link memory and result registers. Depends on fla_pkg and fla_ram.
`default_nettype none

module fla_dp #(
	parameter int POOL_DEPTH = fla_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fla_pkg::cmd_t                   cmd,
	output fla_pkg::sts_t                        sts,
	input  wire logic [$clog2(POOL_DEPTH)-1:0]   free_index,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0] cfg_count,
	output logic                                 done,
	output fla_pkg::status_t                     status,
	output logic      [$clog2(POOL_DEPTH)-1:0]   block_index
);

	import fla_pkg::*;

	localparam int IDX_W = $clog2(POOL_DEPTH);
	localparam int CNT_W = $clog2(POOL_DEPTH + 1);
	localparam int RST_CNT = (RESET_COUNT > POOL_DEPTH) ? POOL_DEPTH : RESET_COUNT;
	localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(POOL_DEPTH);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] sweep_q;
	logic [CNT_W-1:0] sat_count;
	logic [CNT_W-1:0] sweep_nxt;
	logic [CNT_W-1:0] sweep_link;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic [CNT_W-1:0] ram_rdata;

	// Saturate the written count to the pool depth
	assign sat_count = (cfg_count > NULL_LINK) ? NULL_LINK : cfg_count;

	// Link of the initial chain at the sweep position
	assign sweep_nxt  = sweep_q + CNT_W'(1);
	assign sweep_link = (sweep_nxt < count_q) ? sweep_nxt : NULL_LINK;

	// Status to the controller
	assign sts.head_null  = (head_q == NULL_LINK);
	assign sts.free_ok    = (CNT_W'(free_index) < count_q);
	assign sts.sweep_done = (sweep_q == count_q);

	// Memory write: sweep or push
	always_comb begin
		if (cmd.push) begin
			ram_we    = 1'b1;
			ram_waddr = free_index;
			ram_wdata = head_q;
		end else begin
			ram_we    = cmd.sweep_en;
			ram_waddr = sweep_q[IDX_W-1:0];
			ram_wdata = sweep_link;
		end
	end

	fla_ram #(
		.WIDTH (CNT_W),
		.DEPTH (POOL_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.read_head),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Count, head and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(RST_CNT);
			head_q  <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.load_count) begin
				count_q <= sat_count;
				head_q  <= (sat_count == '0) ? NULL_LINK : '0;
				sweep_q <= '0;
			end else begin
				if (cmd.sweep_en) begin
					sweep_q <= sweep_nxt;
				end
				if (cmd.push) begin
					head_q <= CNT_W'(free_index);
				end else if (cmd.take_link) begin
					head_q <= ram_rdata;
				end
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status      <= cmd.status;
			block_index <= (cmd.status == ST_GRANTED) ? head_q[IDX_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/free_list_block_allocator.sv
// Top level of the free-list block allocator: controller plus datapath.
// Depends on fla_pkg, fla_ctrl, fla_dp (which holds fla_ram).
//
// Usage:
//   Request: drive opcode (0 allocate, 1 free) and free_index with start
//   high; the request is taken at a clock edge where busy is low.
//   Result: done pulses for one cycle, the cycle after the request is taken,
//   with status (granted, pool empty, freed, index out of range) and
//   block_index (allocated index when granted, else zero). The receiver
//   cannot hold results off; done is never suppressed.
//   Timing: frees keep busy low, so frees may follow back to back. An
//   allocate that is granted holds busy high while the link of the popped
//   head is read from the link RAM (registered read). Allocates that find
//   the pool empty keep busy low as well.
//   block_count_we with block_count sets the number of blocks in use
//   (saturated to POOL_DEPTH) and rebuilds the list. Write it only while
//   idle.
//   Reset and every count write start an initialization sweep that writes
//   the chain 0..count-1 into the link RAM, one entry a cycle, with busy
//   high until the sweep is done (after reset the count is the reset
//   count of 256 saturated to POOL_DEPTH).
`default_nettype none

module free_list_block_allocator #(
	parameter int POOL_DEPTH = fla_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            opcode,
	input  wire logic [$clog2(POOL_DEPTH)-1:0]   free_index,
	input  wire logic                            block_count_we,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0] block_count,
	output logic                                 done,
	output fla_pkg::status_t                     status,
	output logic      [$clog2(POOL_DEPTH)-1:0]   block_index
);

	import fla_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Control
	fla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.cfg_we (block_count_we),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath
	fla_dp #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.free_index  (free_index),
		.cfg_count   (block_count),
		.done        (done),
		.status      (status),
		.block_index (block_index)
	);

endmodule

`default_nettype wire
